// ----- rtl/rlos_pkg.sv -----
// Shared types and constants for the one-wire RGB LED serialiser.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rlos_pkg;

	localparam int COLOR_W    = 24;
	localparam int HOLD_W     = 16;
	localparam int TIME_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int BIT_CNT_W  = 5;

	localparam logic [BIT_CNT_W-1:0] FIRST_BIT = BIT_CNT_W'(COLOR_W - 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;

	localparam logic [TIME_W-1:0] ONE_HIGH_RST  = 8'd38;
	localparam logic [TIME_W-1:0] ONE_LOW_RST   = 8'd22;
	localparam logic [TIME_W-1:0] ZERO_HIGH_RST = 8'd19;
	localparam logic [TIME_W-1:0] ZERO_LOW_RST  = 8'd41;
	localparam logic [HOLD_W-1:0] LATCH_RST     = 16'd2500;

	typedef struct packed {
		logic [TIME_W-1:0] one_high;
		logic [TIME_W-1:0] one_low;
		logic [TIME_W-1:0] zero_high;
		logic [TIME_W-1:0] zero_low;
		logic [HOLD_W-1:0] latch;
	} cfg_regs_t;

	// pixel already in wire order: green, red, blue
	typedef struct packed {
		logic [COLOR_W-1:0] word;
		logic               last;
	} entry_t;

	typedef struct packed {
		logic   empty;
		entry_t head;
	} q_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HIGH,
		ST_LOW,
		ST_LATCH
	} state_t;

	// a zero time is replaced by the least nonzero hold
	function automatic logic [HOLD_W-1:0] hold_of(input logic [HOLD_W-1:0] v);
		hold_of = (v == '0) ? HOLD_W'(1) : v;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/rlos_pixel_if.sv -----
// Pixel input channel: valid/ready plus packed colour and last-pixel flag.
// Depends on rlos_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rlos_pixel_if;
	logic                          valid;
	logic                          ready;
	logic [rlos_pkg::COLOR_W-1:0]  pixel_color;
	logic                          last_pixel;

	modport source (output valid, output pixel_color, output last_pixel, input ready);
	modport sink   (input valid, input pixel_color, input last_pixel, output ready);
endinterface

`default_nettype wire

// ----- rtl/rlos_seg_if.sv -----
// Segment output channel: valid/ready plus line level, hold time and run end.
// Depends on rlos_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rlos_seg_if;
	logic                         valid;
	logic                         ready;
	logic                         line_level;
	logic [rlos_pkg::HOLD_W-1:0]  hold_cycles;
	logic                         run_end;

	modport source (output valid, output line_level, output hold_cycles, output run_end,
		input ready);
	modport sink   (input valid, input line_level, input hold_cycles, input run_end,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/rlos_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// Depends on rlos_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rlos_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rlos_pkg::CFG_IDX_W-1:0]   index;
	logic [rlos_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/rlos_front.sv -----
// Front end: accepts pixel beats, reorders bytes to wire order, hands them to the queue.
// Depends on rlos_pkg and rlos_pixel_if.
`timescale 1ns / 1ps
`default_nettype none

module rlos_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	rlos_pixel_if.sink         pixel,
	input  wire logic          q_full,
	output logic               push,
	output rlos_pkg::entry_t   push_entry
);

	logic             valid_s1;
	rlos_pkg::entry_t entry_s1;
	logic             take;

	assign push        = valid_s1 && !q_full;
	assign pixel.ready = !valid_s1 || !q_full;
	assign take        = pixel.valid && pixel.ready;
	assign push_entry  = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// G, R, B on the wire
	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1.word <= {pixel.pixel_color[15:8], pixel.pixel_color[23:16],
				pixel.pixel_color[7:0]};
			entry_s1.last <= pixel.last_pixel;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rlos_queue.sv -----
// Two-entry pixel queue between front and back ends.
// Depends on rlos_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlos_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  rlos_pkg::entry_t       push_entry,
	output logic                   full,
	input  wire logic              pop,
	output rlos_pkg::q_status_t    status
);

	rlos_pkg::entry_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full         = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign status.head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rlos_back.sv -----
// Back end: walks the 24 bits of a queued pixel and issues high/low segments,
// plus the latch gap after the last pixel. Depends on rlos_pkg and rlos_seg_if.
`timescale 1ns / 1ps
`default_nettype none

module rlos_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  rlos_pkg::cfg_regs_t    cfg_regs,
	input  rlos_pkg::q_status_t    status,
	output logic                   pop,
	rlos_seg_if.source             seg
);

	rlos_pkg::state_t state_q, state_d;

	logic [rlos_pkg::COLOR_W-1:0]   word_q;
	logic                           last_q;
	logic [rlos_pkg::BIT_CNT_W-1:0] bit_q;

	logic                           seg_valid_q;
	logic                           level_q;
	logic [rlos_pkg::HOLD_W-1:0]    hold_q;
	logic                           end_q;

	logic                           adv;
	logic                           cur_one;
	logic                           final_bit;
	logic                           load_seg;
	logic                           level_d;
	logic [rlos_pkg::HOLD_W-1:0]    raw_d;
	logic                           end_d;

	assign adv       = !seg_valid_q || seg.ready;
	assign cur_one   = word_q[bit_q];
	assign final_bit = (bit_q == '0);

	assign seg.valid       = seg_valid_q;
	assign seg.line_level  = level_q;
	assign seg.hold_cycles = hold_q;
	assign seg.run_end     = end_q;

	// next state
	always_comb begin
		state_d = state_q;
		if (adv) begin
			unique case (state_q)
				rlos_pkg::ST_IDLE: begin
					if (!status.empty) begin
						state_d = rlos_pkg::ST_HIGH;
					end
				end
				rlos_pkg::ST_HIGH: begin
					state_d = rlos_pkg::ST_LOW;
				end
				rlos_pkg::ST_LOW: begin
					if (!final_bit) begin
						state_d = rlos_pkg::ST_HIGH;
					end else if (last_q) begin
						state_d = rlos_pkg::ST_LATCH;
					end else begin
						state_d = rlos_pkg::ST_IDLE;
					end
				end
				rlos_pkg::ST_LATCH: begin
					state_d = rlos_pkg::ST_IDLE;
				end
				default: state_d = rlos_pkg::ST_IDLE;
			endcase
		end
	end

	// outputs
	always_comb begin
		pop      = 1'b0;
		load_seg = 1'b0;
		level_d  = 1'b0;
		raw_d    = '0;
		end_d    = 1'b0;
		unique case (state_q)
			rlos_pkg::ST_IDLE: begin
				pop = adv && !status.empty;
			end
			rlos_pkg::ST_HIGH: begin
				load_seg = adv;
				level_d  = 1'b1;
				raw_d    = rlos_pkg::HOLD_W'(cur_one ? cfg_regs.one_high : cfg_regs.zero_high);
			end
			rlos_pkg::ST_LOW: begin
				load_seg = adv;
				raw_d    = rlos_pkg::HOLD_W'(cur_one ? cfg_regs.one_low : cfg_regs.zero_low);
				end_d    = final_bit && !last_q;
			end
			rlos_pkg::ST_LATCH: begin
				load_seg = adv;
				raw_d    = cfg_regs.latch;
				end_d    = 1'b1;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rlos_pkg::ST_IDLE;
			seg_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				seg_valid_q <= load_seg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= status.head.word;
			last_q <= status.head.last;
			bit_q  <= rlos_pkg::FIRST_BIT;
		end else if (adv && state_q == rlos_pkg::ST_LOW && !final_bit) begin
			bit_q <= bit_q - rlos_pkg::BIT_CNT_W'(1);
		end
		if (load_seg) begin
			level_q <= level_d;
			hold_q  <= rlos_pkg::hold_of(raw_d);
			end_q   <= end_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rgb_led_one_wire_serializer_unit.sv -----
// One-wire RGB LED serialiser: each pixel beat yields 48 segment beats, 49 on the last pixel.
// A pixel passes the front stage, the queue and the back end before its first segment beat.
// The back end sets the pixel rate: it issues one segment per cycle while seg.ready holds,
// and fetches each pixel from the queue in its idle state; a 2-deep queue decouples input.
// Reset: asynchronous, active low; empties queue and pipeline, timing registers to defaults.
// Depends on rlos_pkg, the channel interfaces, rlos_front, rlos_queue and rlos_back.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_one_wire_serializer_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rlos_pixel_if.sink  pixel,
	rlos_seg_if.source  seg,
	rlos_cfg_if.sink    cfg
);

	rlos_pkg::cfg_regs_t cfg_regs_q;
	rlos_pkg::entry_t    push_entry;
	rlos_pkg::q_status_t status;
	logic                push;
	logic                pop;
	logic                q_full;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.one_high  <= rlos_pkg::ONE_HIGH_RST;
			cfg_regs_q.one_low   <= rlos_pkg::ONE_LOW_RST;
			cfg_regs_q.zero_high <= rlos_pkg::ZERO_HIGH_RST;
			cfg_regs_q.zero_low  <= rlos_pkg::ZERO_LOW_RST;
			cfg_regs_q.latch     <= rlos_pkg::LATCH_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rlos_pkg::REG_ONE_HIGH:  cfg_regs_q.one_high  <= cfg.data[7:0];
				rlos_pkg::REG_ONE_LOW:   cfg_regs_q.one_low   <= cfg.data[7:0];
				rlos_pkg::REG_ZERO_HIGH: cfg_regs_q.zero_high <= cfg.data[7:0];
				rlos_pkg::REG_ZERO_LOW:  cfg_regs_q.zero_low  <= cfg.data[7:0];
				rlos_pkg::REG_LATCH:     cfg_regs_q.latch     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	rlos_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	rlos_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.status     (status)
	);

	rlos_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_regs_q),
		.status   (status),
		.pop      (pop),
		.seg      (seg)
	);

endmodule

`default_nettype wire
